>>> src/asidba_pkg.sv
// ----------------------------------------------------------------------------
// asidba_pkg
// Shared codes for the ASID bitmap allocator: request kinds, result status,
// current generation and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package asidba_pkg;

    // request kind (travels on s_tuser)
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status (travels on m_tuser)
    localparam logic [1:0] ST_HELD  = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FREED = 2'd3;

    // the only generation ever handed out
    localparam logic [15:0] CUR_GEN = 16'd1;

    // register map
    localparam logic REG_ASID_WIDTH = 1'b0;
    localparam int   CFG_W          = 5;
    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET = 5'd16;
    localparam logic [CFG_W-1:0] WIDTH_MIN       = 5'd8;

    // bitmap word geometry
    localparam int WORD_BITS   = 64;
    localparam int BIT_IDX_W   = 6;

endpackage : asidba_pkg

`default_nettype wire

>>> src/asid_bitmap_allocator.sv
// A hit on the current generation goes straight to the result state; a free goes
// through read, modify-write and result. An allocation scans one 64-bit bitmap
// word per cycle. One request at a time; s_tready stays low until the sequencer
// is back in idle. After reset a clearing pass writes every bitmap word before
// the first transaction.
// ----------------------------------------------------------------------------
// asid_bitmap_allocator
// Hands out and takes back ASID numbers held in a bitmap memory, searching
// one word per cycle with a shared mask and priority-encode unit.
// ----------------------------------------------------------------------------
`default_nettype none

module asid_bitmap_allocator #(
    parameter int ASID_BITS_MAX = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] ctx_version, [31:16] ctx_asid
    input  wire logic [0:0]  s_tuser,   // [0] req_type

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] out_version, [31:16] out_asid
    output logic [1:0]       m_tuser,   // [1:0] status

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int P      = ASID_BITS_MAX;
    localparam int W      = P - asidba_pkg::BIT_IDX_W;   // word index width
    localparam int WB     = asidba_pkg::WORD_BITS;
    localparam int BW     = asidba_pkg::BIT_IDX_W;
    localparam int NWORDS = 1 << W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } state_t;

    // ---------------------------------------------------------------- storage
    logic [WB-1:0] map_mem [NWORDS];
    logic [WB-1:0] rd_data_reg;
    logic [W-1:0]  rd_addr;
    logic          mem_we;
    logic [W-1:0]  mem_wa;
    logic [WB-1:0] mem_wd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= map_mem[rd_addr];
    end

    // ---------------------------------------------------------------- state
    state_t                       state_reg, state_next;
    logic [asidba_pkg::CFG_W-1:0] cfg_width_reg, cfg_width_next;
    logic [P-1:0]                 lg_reg, lg_next;          // last number given
    logic [P:0]                   start_reg, start_next;
    logic                         phase_reg, phase_next;    // 0 upward, 1 wrapped
    logic [W:0]                   scan_word_reg, scan_word_next;
    logic [W-1:0]                 end_word_reg, end_word_next;
    logic [W-1:0]                 chk_word_reg, chk_word_next;
    logic                         chk_vld_reg, chk_vld_next;
    logic [15:0]                  in_version_reg, in_version_next;
    logic [15:0]                  in_asid_reg, in_asid_next;
    logic [15:0]                  res_version_reg, res_version_next;
    logic [15:0]                  res_asid_reg, res_asid_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [31:0]                  m_tdata_reg, m_tdata_next;
    logic [1:0]                   m_tuser_reg, m_tuser_next;

    // ---------------------------------------------------------------- search unit
    logic [asidba_pkg::CFG_W-1:0] bits_eff;
    logic [P:0]                   top;
    logic [W:0]                   top_words;
    logic [P:0]                   start_new;
    logic [WB-1:0]                cand;
    logic                         cand_any;
    logic [BW-1:0]                cand_bit;
    logic [P-1:0]                 found_num;
    logic                         s_acc;
    logic                         cfg_wr;

    always_comb begin
        bits_eff = cfg_width_reg;
        if (cfg_width_reg < asidba_pkg::WIDTH_MIN) begin
            bits_eff = asidba_pkg::WIDTH_MIN;
        end else if (cfg_width_reg > asidba_pkg::CFG_W'(P)) begin
            bits_eff = asidba_pkg::CFG_W'(P);
        end
    end

    assign top       = (P+1)'(1) << bits_eff;
    assign top_words = top[P:BW];
    assign start_new = {1'b0, lg_reg} + (P+1)'(1);

    // free bits of the word under test, restricted to the live search range
    always_comb begin
        for (int i = 0; i < WB; i++) begin
            if (!phase_reg) begin
                cand[i] = !rd_data_reg[i]
                          && !(({1'b0, chk_word_reg} == start_reg[P:BW])
                               && (BW'(i) < start_reg[BW-1:0]));
            end else begin
                cand[i] = !rd_data_reg[i]
                          && !((chk_word_reg == '0) && (i == 0))
                          && !((chk_word_reg == lg_reg[P-1:BW])
                               && (BW'(i) > lg_reg[BW-1:0]));
            end
        end
    end

    // lowest set bit wins
    always_comb begin
        cand_any = |cand;
        cand_bit = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (cand[i]) begin
                cand_bit = BW'(i);
            end
        end
    end

    assign found_num = {chk_word_reg, cand_bit};

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign rd_addr  = (state_reg == S_IDLE) ? s_tdata[16+BW +: W] : scan_word_reg[W-1:0];

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next       = state_reg;
        cfg_width_next   = cfg_width_reg;
        lg_next          = lg_reg;
        start_next       = start_reg;
        phase_next       = phase_reg;
        scan_word_next   = scan_word_reg;
        end_word_next    = end_word_reg;
        chk_word_next    = chk_word_reg;
        chk_vld_next     = 1'b0;
        in_version_next  = in_version_reg;
        in_asid_next     = in_asid_reg;
        res_version_next = res_version_reg;
        res_asid_next    = res_asid_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        mem_we           = 1'b0;
        mem_wa           = scan_word_reg[W-1:0];
        mem_wd           = '0;

        if (cfg_wr) begin
            cfg_width_next = pwdata[asidba_pkg::CFG_W-1:0];
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = (scan_word_reg[W-1:0] == '0) ? WB'(1) : '0;
                if (scan_word_reg[W-1:0] == W'(NWORDS - 1)) begin
                    scan_word_next = '0;
                    state_next     = S_IDLE;
                end else begin
                    scan_word_next = scan_word_reg + (W+1)'(1);
                end
            end

            S_IDLE: begin
                if (s_acc) begin
                    in_version_next = s_tdata[15:0];
                    in_asid_next    = s_tdata[31:16];
                    if (s_tuser[0] == asidba_pkg::REQ_FREE) begin
                        state_next = S_FREE;
                    end else if (s_tdata[15:0] == asidba_pkg::CUR_GEN) begin
                        res_version_next = s_tdata[15:0];
                        res_asid_next    = s_tdata[31:16];
                        res_status_next  = asidba_pkg::ST_HELD;
                        state_next       = S_DONE;
                    end else begin
                        start_next = start_new;
                        if (start_new < top) begin
                            phase_next     = 1'b0;
                            scan_word_next = start_new[P:BW];
                            end_word_next  = W'(top_words - (W+1)'(1));
                        end else begin
                            // nothing left above the start point
                            phase_next     = 1'b1;
                            scan_word_next = '0;
                            end_word_next  = lg_reg[P-1:BW];
                        end
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue the next word read while the previous one is tested
                if (scan_word_reg <= {1'b0, end_word_reg}) begin
                    scan_word_next = scan_word_reg + (W+1)'(1);
                    chk_vld_next   = 1'b1;
                    chk_word_next  = scan_word_reg[W-1:0];
                end
                if (chk_vld_reg) begin
                    if (cand_any) begin
                        mem_we           = 1'b1;
                        mem_wa           = chk_word_reg;
                        mem_wd           = rd_data_reg | (WB'(1) << cand_bit);
                        lg_next          = found_num;
                        res_version_next = asidba_pkg::CUR_GEN;
                        res_asid_next    = 16'(found_num);
                        res_status_next  = asidba_pkg::ST_NEW;
                        chk_vld_next     = 1'b0;
                        state_next       = S_DONE;
                    end else if (chk_word_reg == end_word_reg) begin
                        chk_vld_next = 1'b0;
                        if (!phase_reg) begin
                            phase_next     = 1'b1;
                            scan_word_next = '0;
                            end_word_next  = lg_reg[P-1:BW];
                        end else begin
                            res_version_next = in_version_reg;
                            res_asid_next    = in_asid_reg;
                            res_status_next  = asidba_pkg::ST_EMPTY;
                            state_next       = S_DONE;
                        end
                    end
                end
            end

            S_FREE: begin
                mem_we           = 1'b1;
                mem_wa           = in_asid_reg[BW +: W];
                mem_wd           = rd_data_reg & ~(WB'(1) << in_asid_reg[BW-1:0]);
                res_version_next = in_version_reg;
                res_asid_next    = in_asid_reg;
                res_status_next  = asidba_pkg::ST_FREED;
                state_next       = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_asid_reg, res_version_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cfg_width_reg <= asidba_pkg::CFG_WIDTH_RESET;
            lg_reg        <= '0;
            phase_reg     <= 1'b0;
            scan_word_reg <= '0;
            chk_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cfg_width_reg   <= cfg_width_next;
            lg_reg          <= lg_next;
            start_reg       <= start_next;
            phase_reg       <= phase_next;
            scan_word_reg   <= scan_word_next;
            end_word_reg    <= end_word_next;
            chk_word_reg    <= chk_word_next;
            chk_vld_reg     <= chk_vld_next;
            in_version_reg  <= in_version_next;
            in_asid_reg     <= in_asid_next;
            res_version_reg <= res_version_next;
            res_asid_reg    <= res_asid_next;
            res_status_reg  <= res_status_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
            m_tuser_reg     <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == asidba_pkg::REG_ASID_WIDTH);
    assign prdata = (paddr[2] == asidba_pkg::REG_ASID_WIDTH)
                    ? {{(32 - asidba_pkg::CFG_W){1'b0}}, cfg_width_reg} : 32'd0;

endmodule : asid_bitmap_allocator

`default_nettype wire
